[sv/pi2d_pkg.sv]
// Package with the microcode format, program table and fixed-point helpers of the integrator.
`timescale 1ns / 1ps
package pi2d_pkg;

    localparam int QW       = 32;   // Q16.16 word width
    localparam int MULW     = 33;   // signed multiplier operand width
    localparam int PRODW    = 2 * MULW;
    localparam int SHW      = PRODW - 16;   // product after the 16-bit fraction drop
    localparam int SUMW     = SHW + 1;
    localparam int TOTW     = SUMW + 1;
    localparam int PCW      = 5;
    localparam int OPW      = 3;
    localparam int CFG_IDXW = 2;

    // Item operations.
    localparam logic [OPW-1:0] OP_ADD_FORCE = 3'd0;
    localparam logic [OPW-1:0] OP_CLR_FORCE = 3'd1;
    localparam logic [OPW-1:0] OP_STEP      = 3'd2;
    localparam logic [OPW-1:0] OP_LOAD_VEL  = 3'd3;
    localparam logic [OPW-1:0] OP_LOAD_POS  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDXW-1:0] CFG_RECIP_MASS = 2'd0;
    localparam logic [CFG_IDXW-1:0] CFG_STEP_TIME  = 2'd1;
    localparam logic [CFG_IDXW-1:0] CFG_DAMPING    = 2'd2;

    localparam logic [31:0] RECIP_MASS_RST = 32'd0;
    localparam logic [15:0] STEP_TIME_RST  = 16'd1092;
    localparam logic [16:0] DAMPING_RST    = 17'd65525;

    // Program entry points.
    localparam logic [PCW-1:0] PC_STEP      = 5'd0;
    localparam logic [PCW-1:0] PC_ADD_FORCE = 5'd12;
    localparam logic [PCW-1:0] PC_CLR_FORCE = 5'd13;
    localparam logic [PCW-1:0] PC_LOAD_VEL  = 5'd14;
    localparam logic [PCW-1:0] PC_LOAD_POS  = 5'd15;
    localparam logic [PCW-1:0] PC_NOP       = 5'd16;
    localparam logic [PCW-1:0] PC_LAST      = 5'd16;

    typedef enum logic [1:0] {A_DT, A_FORCE, A_VEL, A_ACCEL} t_asel;
    typedef enum logic [1:0] {B_DT, B_IMASS, B_DTSQ, B_DAMP} t_bsel;
    typedef enum logic [1:0] {SH_0, SH_16, SH_33} t_shift;
    typedef enum logic {SEQ_NEXT, SEQ_DONE} t_seq;
    typedef enum logic [3:0] {
        WB_NONE, WB_DTSQ, WB_ACCEL, WB_SUM_POS, WB_SUM_LOAD, WB_POS, WB_VEL,
        WB_FADD, WB_FCLR, WB_LDVEL, WB_LDPOS
    } t_wb;

    // One control word. The arithmetic write-back fields act on the product of the previous step.
    typedef struct packed {
        t_asel  a_sel;
        t_bsel  b_sel;
        logic   mul_axis;   // 0 = x, 1 = y
        t_wb    wb;
        logic   wb_axis;
        t_shift shift;
        t_seq   seq;
    } t_uword;

    function automatic t_uword uw(t_asel a, t_bsel b, logic ma, t_wb w, logic wa,
                                  t_shift s, t_seq q);
        t_uword u;
        u.a_sel    = a;
        u.b_sel    = b;
        u.mul_axis = ma;
        u.wb       = w;
        u.wb_axis  = wa;
        u.shift    = s;
        u.seq      = q;
        return u;
    endfunction

    // Program store. Steps 0 to 11 integrate both axes with one shared multiplier.
    function automatic t_uword ucode(logic [PCW-1:0] pc);
        t_uword u;
        case (pc)
            5'd0:  u = uw(A_DT,    B_DT,    1'b0, WB_NONE,     1'b0, SH_0,  SEQ_NEXT);
            5'd1:  u = uw(A_FORCE, B_IMASS, 1'b0, WB_DTSQ,     1'b0, SH_0,  SEQ_NEXT);
            5'd2:  u = uw(A_VEL,   B_DT,    1'b0, WB_ACCEL,    1'b0, SH_16, SEQ_NEXT);
            5'd3:  u = uw(A_ACCEL, B_DTSQ,  1'b0, WB_SUM_POS,  1'b0, SH_16, SEQ_NEXT);
            5'd4:  u = uw(A_VEL,   B_DAMP,  1'b0, WB_POS,      1'b0, SH_33, SEQ_NEXT);
            5'd5:  u = uw(A_ACCEL, B_DT,    1'b0, WB_SUM_LOAD, 1'b0, SH_16, SEQ_NEXT);
            5'd6:  u = uw(A_FORCE, B_IMASS, 1'b1, WB_VEL,      1'b0, SH_16, SEQ_NEXT);
            5'd7:  u = uw(A_VEL,   B_DT,    1'b1, WB_ACCEL,    1'b1, SH_16, SEQ_NEXT);
            5'd8:  u = uw(A_ACCEL, B_DTSQ,  1'b1, WB_SUM_POS,  1'b1, SH_16, SEQ_NEXT);
            5'd9:  u = uw(A_VEL,   B_DAMP,  1'b1, WB_POS,      1'b1, SH_33, SEQ_NEXT);
            5'd10: u = uw(A_ACCEL, B_DT,    1'b1, WB_SUM_LOAD, 1'b1, SH_16, SEQ_NEXT);
            5'd11: u = uw(A_DT,    B_DT,    1'b1, WB_VEL,      1'b1, SH_16, SEQ_DONE);
            5'd12: u = uw(A_DT,    B_DT,    1'b0, WB_FADD,     1'b0, SH_0,  SEQ_DONE);
            5'd13: u = uw(A_DT,    B_DT,    1'b0, WB_FCLR,     1'b0, SH_0,  SEQ_DONE);
            5'd14: u = uw(A_DT,    B_DT,    1'b0, WB_LDVEL,    1'b0, SH_0,  SEQ_DONE);
            5'd15: u = uw(A_DT,    B_DT,    1'b0, WB_LDPOS,    1'b0, SH_0,  SEQ_DONE);
            default: u = uw(A_DT,  B_DT,    1'b0, WB_NONE,     1'b0, SH_0,  SEQ_DONE);
        endcase
        return u;
    endfunction

    // Entry point for each operation; undefined codes run a single empty step.
    function automatic logic [PCW-1:0] entry_pc(logic [OPW-1:0] op);
        logic [PCW-1:0] pc;
        unique case (op)
            OP_ADD_FORCE: pc = PC_ADD_FORCE;
            OP_CLR_FORCE: pc = PC_CLR_FORCE;
            OP_STEP:      pc = PC_STEP;
            OP_LOAD_VEL:  pc = PC_LOAD_VEL;
            OP_LOAD_POS:  pc = PC_LOAD_POS;
            default:      pc = PC_NOP;
        endcase
        return pc;
    endfunction

    function automatic logic signed [QW-1:0] sat32(logic signed [TOTW-1:0] v);
        logic signed [TOTW-1:0] hi;
        logic signed [TOTW-1:0] lo;
        hi = TOTW'(64'sh7FFF_FFFF);
        lo = -TOTW'(64'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[QW-1:0];
    endfunction

endpackage

[sv/pi2d_in_if.sv]
// Input channel: one operation word with its operand vector.
`timescale 1ns / 1ps
interface pi2d_in_if;
    logic                valid;
    logic                ready;
    logic [2:0]          operation;
    logic signed [31:0]  value_x;
    logic signed [31:0]  value_y;

    modport source (output valid, output operation, output value_x, output value_y,
                    input ready);
    modport sink (input valid, input operation, input value_x, input value_y,
                  output ready);
endinterface

[sv/pi2d_out_if.sv]
// Output channel: position and velocity after each word.
`timescale 1ns / 1ps
interface pi2d_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  out_pos_x;
    logic signed [31:0]  out_pos_y;
    logic signed [31:0]  out_vel_x;
    logic signed [31:0]  out_vel_y;

    modport source (output valid, output out_pos_x, output out_pos_y,
                    output out_vel_x, output out_vel_y, input ready);
    modport sink (input valid, input out_pos_x, input out_pos_y,
                  input out_vel_x, input out_vel_y, output ready);
endinterface

[sv/particle_integrator_2d.sv]
// An integration step runs the full integration program after acceptance; other operations
// run a single sequencer step. The result is then registered in the output register.
// A new word is taken only when no program is running; the microprogram uses the
// single shared 33x33 multiplier once per step.
// Reset (synchronous, active low) zeroes the particle state and loads the register defaults.
`timescale 1ns / 1ps
module particle_integrator_2d (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pi2d_in_if.sink                       i_in,
    pi2d_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [pi2d_pkg::CFG_IDXW-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_PUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_recip_mass;
    logic [15:0] r_step_time;
    logic [16:0] r_damping;

    logic signed [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_force_x, r_force_y;
    logic signed [31:0] r_in_x, r_in_y;
    logic signed [31:0] r_accel;
    logic [31:0]        r_dtsq;
    logic signed [pi2d_pkg::PRODW-1:0] r_prod;
    logic signed [pi2d_pkg::SUMW-1:0]  r_sum;
    logic [pi2d_pkg::PCW-1:0]          r_pc;

    logic               r_out_valid;
    logic signed [31:0] r_out_pos_x, r_out_pos_y, r_out_vel_x, r_out_vel_y;

    pi2d_pkg::t_uword u;
    logic signed [pi2d_pkg::MULW-1:0] mul_a, mul_b;
    logic signed [pi2d_pkg::SHW-1:0]  sh;
    logic signed [31:0]               pos_sel, wb_pos, wb_vel;
    logic signed [pi2d_pkg::TOTW-1:0] sum_pos, sum_tot;
    logic                             out_free, in_acc, run;

    assign u        = pi2d_pkg::ucode(r_pc);
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) || ((r_state == ST_PUT) && out_free);
    assign in_acc   = i_in.valid && i_in.ready;
    assign run      = (r_state == ST_RUN);

    // Multiplier operand selection.
    always_comb begin
        case (u.a_sel)
            pi2d_pkg::A_DT:    mul_a = {17'd0, r_step_time};
            pi2d_pkg::A_FORCE: mul_a = u.mul_axis ? {r_force_y[31], r_force_y}
                                                  : {r_force_x[31], r_force_x};
            pi2d_pkg::A_VEL:   mul_a = u.mul_axis ? {r_vel_y[31], r_vel_y}
                                                  : {r_vel_x[31], r_vel_x};
            default:           mul_a = {r_accel[31], r_accel};
        endcase
        case (u.b_sel)
            pi2d_pkg::B_DT:    mul_b = {17'd0, r_step_time};
            pi2d_pkg::B_IMASS: mul_b = {1'b0, r_recip_mass};
            pi2d_pkg::B_DTSQ:  mul_b = {1'b0, r_dtsq};
            default:           mul_b = {16'd0, r_damping};
        endcase
    end

    // Arithmetic shifts of the previous product round toward minus infinity.
    always_comb begin
        case (u.shift)
            pi2d_pkg::SH_16: sh = r_prod[pi2d_pkg::PRODW-1:16];
            pi2d_pkg::SH_33: sh = {{(pi2d_pkg::SHW - (pi2d_pkg::PRODW - 33))
                                    {r_prod[pi2d_pkg::PRODW-1]}},
                                   r_prod[pi2d_pkg::PRODW-1:33]};
            default:         sh = r_prod[pi2d_pkg::SHW-1:0];
        endcase
    end

    assign pos_sel = u.wb_axis ? r_pos_y : r_pos_x;
    assign sum_pos = {{(pi2d_pkg::TOTW-32){pos_sel[31]}}, pos_sel}
                   + {{(pi2d_pkg::TOTW-pi2d_pkg::SHW){sh[pi2d_pkg::SHW-1]}}, sh};
    assign sum_tot = {{(pi2d_pkg::TOTW-pi2d_pkg::SUMW){r_sum[pi2d_pkg::SUMW-1]}}, r_sum}
                   + {{(pi2d_pkg::TOTW-pi2d_pkg::SHW){sh[pi2d_pkg::SHW-1]}}, sh};
    assign wb_pos  = pi2d_pkg::sat32(sum_tot);
    assign wb_vel  = pi2d_pkg::sat32(sum_tot);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (u.seq == pi2d_pkg::SEQ_DONE) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (in_acc) begin
                    n_state = ST_RUN;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= pi2d_pkg::PC_NOP;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_pc <= pi2d_pkg::entry_pc(i_in.operation);
            end else if (run) begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip_mass <= pi2d_pkg::RECIP_MASS_RST;
            r_step_time  <= pi2d_pkg::STEP_TIME_RST;
            r_damping    <= pi2d_pkg::DAMPING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pi2d_pkg::CFG_RECIP_MASS: r_recip_mass <= i_cfg_data;
                pi2d_pkg::CFG_STEP_TIME:  r_step_time  <= i_cfg_data[15:0];
                pi2d_pkg::CFG_DAMPING:    r_damping    <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Datapath scratch registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_x <= i_in.value_x;
            r_in_y <= i_in.value_y;
        end
        if (run) begin
            r_prod <= mul_a * mul_b;
            case (u.wb)
                pi2d_pkg::WB_DTSQ:     r_dtsq  <= r_prod[31:0];
                pi2d_pkg::WB_ACCEL:    r_accel <= pi2d_pkg::sat32(
                    {{(pi2d_pkg::TOTW-pi2d_pkg::SHW){sh[pi2d_pkg::SHW-1]}}, sh});
                pi2d_pkg::WB_SUM_POS:  r_sum   <= sum_pos[pi2d_pkg::SUMW-1:0];
                pi2d_pkg::WB_SUM_LOAD: r_sum   <= {sh[pi2d_pkg::SHW-1], sh};
                default: ;
            endcase
        end
    end

    // Particle state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_vel_x   <= '0;
            r_vel_y   <= '0;
            r_force_x <= '0;
            r_force_y <= '0;
        end else if (run) begin
            case (u.wb)
                pi2d_pkg::WB_POS: begin
                    if (u.wb_axis) begin
                        r_pos_y <= wb_pos;
                    end else begin
                        r_pos_x <= wb_pos;
                    end
                end
                pi2d_pkg::WB_VEL: begin
                    if (u.wb_axis) begin
                        r_vel_y <= wb_vel;
                    end else begin
                        r_vel_x <= wb_vel;
                    end
                end
                pi2d_pkg::WB_FADD: begin
                    r_force_x <= pi2d_pkg::sat32(pi2d_pkg::TOTW'(r_force_x)
                                                 + pi2d_pkg::TOTW'(r_in_x));
                    r_force_y <= pi2d_pkg::sat32(pi2d_pkg::TOTW'(r_force_y)
                                                 + pi2d_pkg::TOTW'(r_in_y));
                end
                pi2d_pkg::WB_FCLR: begin
                    r_force_x <= '0;
                    r_force_y <= '0;
                end
                pi2d_pkg::WB_LDVEL: begin
                    r_vel_x <= r_in_x;
                    r_vel_y <= r_in_y;
                end
                pi2d_pkg::WB_LDPOS: begin
                    r_pos_x <= r_in_x;
                    r_pos_y <= r_in_y;
                end
                default: ;
            endcase
        end
    end

    // Output register: the result waits here while the next word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_PUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_PUT) && out_free) begin
            r_out_pos_x <= r_pos_x;
            r_out_pos_y <= r_pos_y;
            r_out_vel_x <= r_vel_x;
            r_out_vel_y <= r_vel_y;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_pos_x = r_out_pos_x;
    assign o_out.out_pos_y = r_out_pos_y;
    assign o_out.out_vel_x = r_out_vel_x;
    assign o_out.out_vel_y = r_out_vel_y;

`ifndef ASSERT_OFF
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run |-> (r_pc <= pi2d_pkg::PC_LAST))
        else $error("sequencer left the program store");

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_RUN))
        else $error("accepted word did not start the program");

    a_result_after_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_PUT))
        else $error("result appeared without a finished program");

    a_no_accept_while_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run |-> !i_in.ready)
        else $error("input ready while the program runs");
`endif

endmodule

[test/pi2d_checker.sv]
// Checker that predicts the particle state after each accepted word and compares every result.
`timescale 1ns / 1ps
module pi2d_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pi2d_in_if                            i_in_mon,
    pi2d_out_if                           i_out_mon,
    input  logic                          i_cfg_we,
    input  logic [pi2d_pkg::CFG_IDXW-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);

    typedef logic signed [pi2d_pkg::QW-1:0] t_q16;

    typedef struct packed {
        t_q16 pos_x;
        t_q16 pos_y;
        t_q16 vel_x;
        t_q16 vel_y;
    } t_particle;

    typedef struct packed {
        t_q16 pos;
        t_q16 vel;
    } t_axis;

    localparam longint Q16_MAX = 64'sd2147483647;
    localparam longint Q16_MIN = -64'sd2147483648;

    logic [31:0] recip_mass;
    logic [15:0] step_time;
    logic [16:0] damping;
    t_q16        pos_x, pos_y, vel_x, vel_y, force_x, force_y;
    t_particle   predicted_states[$];

    function automatic t_q16 clamp_q16(longint v);
        if (v > Q16_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (v < Q16_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // One Euler step of one axis. All shifts on signed longints floor toward minus infinity.
    function automatic t_axis advance_axis(t_q16 pos, t_q16 vel, t_q16 frc);
        longint dt;
        longint mass;
        longint accel;
        longint v;
        longint new_pos;
        longint new_vel;
        t_axis  nxt;
        dt      = step_time;
        mass    = recip_mass;
        v       = vel;
        accel   = clamp_q16((longint'(frc) * mass) >>> 16);
        new_pos = longint'(pos) + ((v * dt) >>> 16) + ((accel * (dt * dt)) >>> 33);
        new_vel = ((v * longint'(damping)) >>> 16) + ((accel * dt) >>> 16);
        nxt.pos = clamp_q16(new_pos);
        nxt.vel = clamp_q16(new_vel);
        return nxt;
    endfunction

    always @(posedge i_clk) begin : track
        t_particle got;
        t_particle want;
        t_axis     ax;
        if (!i_rst_n) begin
            recip_mass = pi2d_pkg::RECIP_MASS_RST;
            step_time  = pi2d_pkg::STEP_TIME_RST;
            damping    = pi2d_pkg::DAMPING_RST;
            pos_x      = '0;
            pos_y      = '0;
            vel_x      = '0;
            vel_y      = '0;
            force_x    = '0;
            force_y    = '0;
            predicted_states.delete();
            o_errors   = 0;
            o_pending  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pi2d_pkg::CFG_RECIP_MASS: recip_mass = i_cfg_data;
                    pi2d_pkg::CFG_STEP_TIME:  step_time  = i_cfg_data[15:0];
                    pi2d_pkg::CFG_DAMPING:    damping    = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                case (i_in_mon.operation)
                    pi2d_pkg::OP_ADD_FORCE: begin
                        force_x = clamp_q16(longint'(force_x) + longint'(i_in_mon.value_x));
                        force_y = clamp_q16(longint'(force_y) + longint'(i_in_mon.value_y));
                    end
                    pi2d_pkg::OP_CLR_FORCE: begin
                        force_x = '0;
                        force_y = '0;
                    end
                    pi2d_pkg::OP_STEP: begin
                        ax    = advance_axis(pos_x, vel_x, force_x);
                        pos_x = ax.pos;
                        vel_x = ax.vel;
                        ax    = advance_axis(pos_y, vel_y, force_y);
                        pos_y = ax.pos;
                        vel_y = ax.vel;
                    end
                    pi2d_pkg::OP_LOAD_VEL: begin
                        vel_x = i_in_mon.value_x;
                        vel_y = i_in_mon.value_y;
                    end
                    pi2d_pkg::OP_LOAD_POS: begin
                        pos_x = i_in_mon.value_x;
                        pos_y = i_in_mon.value_y;
                    end
                    default: ;   // Reserved codes leave the particle alone.
                endcase
                want = '{pos_x, pos_y, vel_x, vel_y};
                predicted_states.push_back(want);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.out_pos_x, i_out_mon.out_pos_y,
                        i_out_mon.out_vel_x, i_out_mon.out_vel_y};
                if (predicted_states.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("%0t: result word with nothing pending:", $time);
                        $display("%0t:   pos (%0d, %0d) vel (%0d, %0d)",
                                 $time, $signed(got.pos_x), $signed(got.pos_y),
                                 $signed(got.vel_x), $signed(got.vel_y));
                    end
                end else begin
                    want = predicted_states.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("%0t: mismatch: expected pos (%0d, %0d) vel (%0d, %0d)",
                                     $time, $signed(want.pos_x), $signed(want.pos_y),
                                     $signed(want.vel_x), $signed(want.vel_y));
                            $display("%0t:           got      pos (%0d, %0d) vel (%0d, %0d)",
                                     $time, $signed(got.pos_x), $signed(got.pos_y),
                                     $signed(got.vel_x), $signed(got.vel_y));
                        end
                    end
                end
            end
            o_pending = predicted_states.size();
        end
    end

endmodule

[test/tb.sv]
// Top of the particle integrator testbench: clock, reset, register setup, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

    localparam logic [pi2d_pkg::OPW-1:0] OP_RESERVED_MAX = 3'd7;
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 64;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [pi2d_pkg::CFG_IDXW-1:0] cfg_idx;
    logic [31:0]                   cfg_data;
    int                            idle_pct  = 0;
    int                            stall_pct = 0;
    int                            error_count;
    int                            pending_count;

    pi2d_in_if  in_ch ();
    pi2d_out_if out_ch ();

    particle_integrator_2d i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pi2d_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (error_count),
        .o_pending  (pending_count)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Leaves valid high on return so that back-to-back words need no extra edge.
    task automatic send_word(input logic [pi2d_pkg::OPW-1:0] op,
                             input logic signed [31:0] vx,
                             input logic signed [31:0] vy);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.value_x   <= vx;
        in_ch.value_y   <= vy;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Waits until every result is back and the sequencer has surely gone quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] imass, input logic [15:0] dt,
                             input logic [16:0] damp);
        cfg_we   <= 1'b1;
        cfg_idx  <= pi2d_pkg::CFG_RECIP_MASS;
        cfg_data <= imass;
        @(negedge i_clk);
        cfg_idx  <= pi2d_pkg::CFG_STEP_TIME;
        cfg_data <= {16'd0, dt};
        @(negedge i_clk);
        cfg_idx  <= pi2d_pkg::CFG_DAMPING;
        cfg_data <= {15'd0, damp};
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Half the values lie near the origin so that motion stays unsaturated for a while.
    function automatic logic signed [31:0] random_operand();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5) begin
            return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        end else if (pick < 8) begin
            return $urandom;
        end
        case ($urandom_range(3))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic [pi2d_pkg::OPW-1:0] random_op();
        int unsigned pick;
        int unsigned code;
        pick = $urandom_range(99);
        code = $urandom_range(OP_RESERVED_MAX, pi2d_pkg::OP_LOAD_POS + 1);
        if (pick < 38) return pi2d_pkg::OP_STEP;
        if (pick < 58) return pi2d_pkg::OP_ADD_FORCE;
        if (pick < 70) return pi2d_pkg::OP_LOAD_VEL;
        if (pick < 80) return pi2d_pkg::OP_LOAD_POS;
        if (pick < 90) return pi2d_pkg::OP_CLR_FORCE;
        return code[pi2d_pkg::OPW-1:0];
    endfunction

    initial begin
        logic [31:0] imass;
        logic [15:0] dt;
        logic [16:0] damp;
        in_ch.valid     = 1'b0;
        in_ch.operation = pi2d_pkg::OP_ADD_FORCE;
        in_ch.value_x   = '0;
        in_ch.value_y   = '0;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = pi2d_pkg::CFG_RECIP_MASS;
        cfg_data        = '0;
        i_rst_n         = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: zero inverse mass, so force must not move anything.
        send_word(pi2d_pkg::OP_ADD_FORCE, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(pi2d_pkg::OP_STEP, 32'sh0, 32'sh0);
        send_word(pi2d_pkg::OP_LOAD_VEL, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(pi2d_pkg::OP_STEP, -32'sd1, -32'sd1);
        send_word(pi2d_pkg::OP_LOAD_POS, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(pi2d_pkg::OP_STEP, 32'sh0, 32'sh0);
        for (int k = pi2d_pkg::OP_LOAD_POS + 1; k <= OP_RESERVED_MAX; k++) begin
            send_word(k[pi2d_pkg::OPW-1:0], -32'sd1, 32'sh7FFF_FFFF);
        end
        send_word(pi2d_pkg::OP_CLR_FORCE, -32'sd1, -32'sd1);
        settle();

        // Largest mass inverse, step and a damping factor above one.
        load_regs(32'hFFFF_FFFF, 16'hFFFF, 17'h1_FFFF);
        send_word(pi2d_pkg::OP_ADD_FORCE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_word(pi2d_pkg::OP_ADD_FORCE, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(pi2d_pkg::OP_LOAD_VEL, 32'sh0001_0000, -32'sh0001_0000);
        send_word(pi2d_pkg::OP_STEP, 32'sh0, 32'sh0);
        send_word(pi2d_pkg::OP_STEP, 32'sh0, 32'sh0);
        send_word(pi2d_pkg::OP_LOAD_POS, 32'sh0, 32'sh0);
        send_word(pi2d_pkg::OP_ADD_FORCE, 32'sh8000_0000, 32'sh8000_0000);
        send_word(pi2d_pkg::OP_STEP, 32'sh0, 32'sh0);
        settle();

        // Zero step time and zero damping: position holds, velocity drops to zero.
        load_regs(32'h0001_0000, 16'h0000, 17'h0_0000);
        send_word(pi2d_pkg::OP_LOAD_VEL, 32'sh0005_0000, -32'sh0003_8000);
        send_word(pi2d_pkg::OP_STEP, 32'sh0, 32'sh0);
        send_word(pi2d_pkg::OP_CLR_FORCE, 32'sh0, 32'sh0);
        send_word(pi2d_pkg::OP_ADD_FORCE, 32'sh0002_0000, -32'sh0001_0000);
        send_word(pi2d_pkg::OP_STEP, 32'sh0, 32'sh0);
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    imass = 32'h0001_0000;
                    dt    = pi2d_pkg::STEP_TIME_RST;
                    damp  = pi2d_pkg::DAMPING_RST;
                end
                1: begin
                    imass = 32'hFFFF_FFFF;
                    dt    = 16'hFFFF;
                    damp  = 17'h1_0000;
                end
                2: begin
                    imass = 32'h0000_0000;
                    dt    = 16'h0001;
                    damp  = 17'h1_FFFF;
                end
                default: begin
                    case ($urandom_range(3))
                        0:       imass = 32'h0000_0000;
                        1:       imass = 32'hFFFF_FFFF;
                        2:       imass = $urandom_range(32'h0004_0000);
                        default: imass = $urandom;
                    endcase
                    case ($urandom_range(4))
                        0:       dt = 16'h0000;
                        1:       dt = 16'h0001;
                        2:       dt = 16'hFFFF;
                        default: dt = 16'($urandom_range(16'hFFFF, 1));
                    endcase
                    case ($urandom_range(4))
                        0:       damp = 17'h0_0000;
                        1:       damp = 17'h1_0000;
                        2:       damp = 17'h1_FFFF;
                        default: damp = 17'($urandom_range(17'h1_0000, 60000));
                    endcase
                end
            endcase
            load_regs(imass, dt, damp);

            // Idling pattern cycles through none, sender only, receiver only, both.
            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 71;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 71;
                end
                default: begin
                    idle_pct  = 26;
                    stall_pct = 26;
                end
            endcase

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_word(random_op(), random_operand(), random_operand());
            end
            settle();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (30) @(negedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
